// ===== design/radial_stick_deadzone_core_assert.svh =====
// Assertion macros shared by the radial stick deadzone design.
`ifndef RADIAL_STICK_DEADZONE_CORE_ASSERT_SVH
`define RADIAL_STICK_DEADZONE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RSDZ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsdz: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RSDZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsdz: next-cycle check failed");

`endif

// ===== design/rsdz_pkg.sv =====
// ----------------------------------------------------------------------------
// rsdz_pkg
// Widths, stage counts and side-band types of the stick deadzone pipeline.
// ----------------------------------------------------------------------------
package rsdz_pkg;

  localparam int SUM_W      = 32;
  localparam int MAG_W      = 16;
  localparam int SQ_STAGES  = MAG_W;
  localparam int SQ_REM_W   = MAG_W + 3;
  localparam int DIV_NUM_W  = 33;
  localparam int DIV_DEN_W  = 16;
  localparam int DIV_Q_W    = 17;
  localparam int DIV_LANES  = 3;

  // Data that rides along with the square root.
  typedef struct packed {
    logic        x_neg;
    logic        y_neg;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [14:0] dz;
  } sqrt_side_t;

  // Data that rides along with the dividers.
  typedef struct packed {
    logic        x_neg;
    logic        y_neg;
    logic        mag_zero;
    logic        indz;
    logic        span_zero;
    logic [14:0] adj;
  } div_side_t;

endpackage

// ===== design/rsdz_sqrt.sv =====
// ----------------------------------------------------------------------------
// rsdz_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rsdz_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [rsdz_pkg::SUM_W-1:0]   in_v,
  input  rsdz_pkg::sqrt_side_t         in_side,
  output logic                         out_vld,
  output logic [rsdz_pkg::MAG_W-1:0]   out_root,
  output rsdz_pkg::sqrt_side_t         out_side
);
  import rsdz_pkg::*;

  logic                vld_r  [SQ_STAGES];
  logic [SQ_REM_W-1:0] rem_r  [SQ_STAGES];
  logic [MAG_W-1:0]    root_r [SQ_STAGES];
  logic [SUM_W-1:0]    v_r    [SQ_STAGES];
  sqrt_side_t          side_r [SQ_STAGES];
  logic [SQ_REM_W-1:0] rem_nxt  [SQ_STAGES];
  logic [MAG_W-1:0]    root_nxt [SQ_STAGES];

  // Each stage brings down two radicand bits and settles one root bit.
  always_comb begin
    logic [SQ_REM_W-1:0] rp;
    logic [MAG_W-1:0]    tp;
    logic [SUM_W-1:0]    vp;
    logic [SQ_REM_W-1:0] cur;
    logic [SQ_REM_W-1:0] trial;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        rp = '0;
        tp = '0;
        vp = in_v;
      end else begin
        rp = rem_r[k-1];
        tp = root_r[k-1];
        vp = v_r[k-1];
      end
      cur   = {rp[SQ_REM_W-3:0], vp[SUM_W-1:SUM_W-2]};
      trial = SQ_REM_W'({tp, 2'b01});
      if (cur >= trial) begin
        rem_nxt[k]  = cur - trial;
        root_nxt[k] = {tp[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cur;
        root_nxt[k] = {tp[MAG_W-2:0], 1'b0};
      end
    end
  end

  // Valid bits march with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_STAGES; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < SQ_STAGES; k++) vld_r[k] <= (k == 0) ? in_vld : vld_r[k-1];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        if (k == 0) begin
          v_r[k]    <= in_v << 2;
          side_r[k] <= in_side;
        end else begin
          v_r[k]    <= v_r[k-1] << 2;
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_root = root_r[SQ_STAGES-1];
  assign out_side = side_r[SQ_STAGES-1];

endmodule

// ===== design/rsdz_div.sv =====
// ----------------------------------------------------------------------------
// rsdz_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rsdz_div (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              adv,
  input  logic                                              in_vld,
  input  logic [rsdz_pkg::DIV_LANES-1:0][rsdz_pkg::DIV_NUM_W-1:0] in_num,
  input  logic [rsdz_pkg::DIV_LANES-1:0][rsdz_pkg::DIV_DEN_W-1:0] in_den,
  input  rsdz_pkg::div_side_t                               in_side,
  output logic                                              out_vld,
  output logic [rsdz_pkg::DIV_LANES-1:0][rsdz_pkg::DIV_Q_W-1:0]   out_q,
  output rsdz_pkg::div_side_t                               out_side
);
  import rsdz_pkg::*;

  logic                                  vld_r  [DIV_Q_W];
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0]   rem_r  [DIV_Q_W];
  logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   den_r  [DIV_Q_W];
  logic [DIV_LANES-1:0][DIV_Q_W-1:0]     q_r    [DIV_Q_W];
  div_side_t                             side_r [DIV_Q_W];
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0]   rem_nxt [DIV_Q_W];
  logic [DIV_LANES-1:0][DIV_DEN_W-1:0]   den_nxt [DIV_Q_W];
  logic [DIV_LANES-1:0][DIV_Q_W-1:0]     q_nxt   [DIV_Q_W];

  // Stage k decides quotient bit DIV_Q_W-1-k by one shifted compare.
  always_comb begin
    logic [DIV_NUM_W-1:0] rp;
    logic [DIV_DEN_W-1:0] dp;
    logic [DIV_Q_W-1:0]   qp;
    logic [DIV_NUM_W-1:0] trial;
    for (int k = 0; k < DIV_Q_W; k++) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        if (k == 0) begin
          rp = in_num[l];
          dp = in_den[l];
          qp = '0;
        end else begin
          rp = rem_r[k-1][l];
          dp = den_r[k-1][l];
          qp = q_r[k-1][l];
        end
        trial = DIV_NUM_W'(dp) << (DIV_Q_W - 1 - k);
        den_nxt[k][l] = dp;
        if (rp >= trial) begin
          rem_nxt[k][l] = rp - trial;
          q_nxt[k][l]   = {qp[DIV_Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[k][l] = rp;
          q_nxt[k][l]   = {qp[DIV_Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // Valid bits march with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_Q_W; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < DIV_Q_W; k++) vld_r[k] <= (k == 0) ? in_vld : vld_r[k-1];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_Q_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        den_r[k]  <= den_nxt[k];
        q_r[k]    <= q_nxt[k];
        side_r[k] <= (k == 0) ? in_side : side_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[DIV_Q_W-1];
  assign out_q    = q_r[DIV_Q_W-1];
  assign out_side = side_r[DIV_Q_W-1];

endmodule

// ===== design/radial_stick_deadzone_core.sv =====
// ----------------------------------------------------------------------------
// radial_stick_deadzone_core
// Circular thumbstick deadzone: magnitude, direction and rescaled deflection.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  in_       in_valid / in_stall  in_stick_x, in_stick_y
//  out_      out_valid / out_stall in_deadzone, direction x/y, adjusted, scaled
//  cfg_      cfg_valid / cfg_ready cfg_data (deadzone radius)
//
//  One sample is accepted per cycle while the output is not stalled; the stages are
//  abs, square sum, 16 square root stages, setup, 17 divider stages, output register.
//  The latency is set by the bit-per-stage square root and divider pipelines.
//  Reset is synchronous and clears valid bits and the radius to 7849.
//  A stalled output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "radial_stick_deadzone_core_assert.svh"

module radial_stick_deadzone_core #(
  parameter int AXIS_MAX = 32767
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_stick_x,
  input  logic [15:0] in_stick_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_in_deadzone,
  output logic [15:0] out_direction_x,
  output logic [15:0] out_direction_y,
  output logic [14:0] out_adjusted_magnitude,
  output logic [16:0] out_scaled_magnitude,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);
  import rsdz_pkg::*;

  localparam logic [MAG_W-1:0] AXIS_MAX_M = MAG_W'(AXIS_MAX);
  localparam logic [14:0]      AXIS_MAX_D = 15'(AXIS_MAX);
  localparam logic [14:0]      DZ_RESET   = 15'd7849;

  logic adv;
  logic [14:0] dz_r;

  // Configuration register, always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
    end else if (cfg_valid) begin
      dz_r <= cfg_data;
    end
  end

  // The pipeline moves whenever the output register can take a result.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: absolute values.
  logic        s1_vld_r;
  sqrt_side_t  s1_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r.x_neg <= in_stick_x[15];
      s1_side_r.y_neg <= in_stick_y[15];
      s1_side_r.ax    <= in_stick_x[15] ? (~in_stick_x + 16'd1) : in_stick_x;
      s1_side_r.ay    <= in_stick_y[15] ? (~in_stick_y + 16'd1) : in_stick_y;
      s1_side_r.dz    <= dz_r;
    end
  end

  // Stage 2: sum of squares.
  logic             s2_vld_r;
  sqrt_side_t       s2_side_r;
  logic [SUM_W-1:0] s2_sum_r;
  logic [SUM_W-1:0] pxx;
  logic [SUM_W-1:0] pyy;
  assign pxx = s1_side_r.ax * s1_side_r.ax;
  assign pyy = s1_side_r.ay * s1_side_r.ay;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r <= s1_side_r;
      s2_sum_r  <= pxx + pyy;
    end
  end

  // Square root pipeline.
  logic             sq_vld;
  logic [MAG_W-1:0] mag;
  sqrt_side_t       sq_side;
  rsdz_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (s2_vld_r),
    .in_v     (s2_sum_r),
    .in_side  (s2_side_r),
    .out_vld  (sq_vld),
    .out_root (mag),
    .out_side (sq_side)
  );

  // Setup stage: deadzone test, clip, span and divider operands.
  logic [MAG_W-1:0] m_clip;
  logic [14:0]      adj_c;
  logic [14:0]      span_c;
  logic             span_zero_c;
  logic             mag_zero_c;
  assign m_clip      = (mag > AXIS_MAX_M) ? AXIS_MAX_M : mag;
  assign adj_c       = (m_clip[14:0] > sq_side.dz) ? (m_clip[14:0] - sq_side.dz) : 15'd0;
  assign span_zero_c = !(AXIS_MAX_D > sq_side.dz);
  assign span_c      = AXIS_MAX_D - sq_side.dz;
  assign mag_zero_c  = (mag == '0);

  logic                                s3_vld_r;
  div_side_t                           s3_side_r;
  logic [DIV_LANES-1:0][DIV_NUM_W-1:0] s3_num_r;
  logic [DIV_LANES-1:0][DIV_DEN_W-1:0] s3_den_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= sq_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r.x_neg     <= sq_side.x_neg;
      s3_side_r.y_neg     <= sq_side.y_neg;
      s3_side_r.mag_zero  <= mag_zero_c;
      s3_side_r.indz      <= (mag <= {1'b0, sq_side.dz});
      s3_side_r.span_zero <= span_zero_c;
      s3_side_r.adj       <= adj_c;
      s3_num_r[0] <= {2'b00, sq_side.ax, 15'd0};
      s3_num_r[1] <= {2'b00, sq_side.ay, 15'd0};
      s3_num_r[2] <= {2'b00, adj_c, 16'd0};
      s3_den_r[0] <= mag_zero_c ? DIV_DEN_W'(1) : mag;
      s3_den_r[1] <= mag_zero_c ? DIV_DEN_W'(1) : mag;
      s3_den_r[2] <= span_zero_c ? DIV_DEN_W'(1) : {1'b0, span_c};
    end
  end

  // Divider pipeline for both directions and the rescale.
  logic                              dv_vld;
  logic [DIV_LANES-1:0][DIV_Q_W-1:0] dv_q;
  div_side_t                         dv_side;
  rsdz_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (s3_vld_r),
    .in_num   (s3_num_r),
    .in_den   (s3_den_r),
    .in_side  (s3_side_r),
    .out_vld  (dv_vld),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // Output stage: sign, saturation and the special cases.
  function automatic logic [15:0] dir_fix(logic [DIV_Q_W-1:0] q, logic neg, logic mz);
    logic [15:0] r;
    if (mz) begin
      r = 16'd0;
    end else if (neg) begin
      r = ~q[15:0] + 16'd1;
    end else if (q > DIV_Q_W'(32767)) begin
      r = 16'd32767;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_in_deadzone        <= dv_side.indz;
      out_direction_x        <= dir_fix(dv_q[0], dv_side.x_neg, dv_side.mag_zero);
      out_direction_y        <= dir_fix(dv_q[1], dv_side.y_neg, dv_side.mag_zero);
      out_adjusted_magnitude <= dv_side.indz ? 15'd0 : dv_side.adj;
      if (dv_side.indz) begin
        out_scaled_magnitude <= 17'd0;
      end else if (dv_side.span_zero) begin
        out_scaled_magnitude <= 17'd65536;
      end else begin
        out_scaled_magnitude <= dv_q[2];
      end
    end
  end

  // Flattened views of the result for the checks below.
  logic        dz_out_zero;
  logic [64:0] out_pay;
  assign dz_out_zero = (out_adjusted_magnitude == 15'd0) && (out_scaled_magnitude == 17'd0);
  assign out_pay     = {out_in_deadzone, out_direction_x, out_direction_y,
                        out_adjusted_magnitude, out_scaled_magnitude};

  // A sample inside the deadzone reports no deflection.
  `RSDZ_ASSERT_IMPL(a_dz_zero, clk, rst_n, out_valid && out_in_deadzone, dz_out_zero)
  // Rescaled deflection never exceeds full scale.
  `RSDZ_ASSERT_IMPL(a_scale_max, clk, rst_n, out_valid, out_scaled_magnitude <= 17'd65536)
  // A stalled result is held unchanged.
  `RSDZ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pay))

endmodule

// ===== tb/radial_stick_deadzone_core_tb.sv =====
// ----------------------------------------------------------------------------
// radial_stick_deadzone_core_tb
// Streams stick samples through the deadzone core under several radius
// settings, with random idle bursts on both channels, and checks every
// response against an in-bench predictor of magnitude, direction and scaling.
// ----------------------------------------------------------------------------
module radial_stick_deadzone_core_tb;

  localparam int AXIS_MAX   = 32767;
  localparam int HALF_CLK   = 6;
  localparam int DRAIN_WAIT = 45;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
  } sample_t;

  typedef struct packed {
    logic        in_dz;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [14:0] adj;
    logic [16:0] scaled;
  } stick_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_stick_x;
  logic [15:0] in_stick_y;
  logic        out_valid;
  logic        out_stall;
  logic        out_in_deadzone;
  logic [15:0] out_direction_x;
  logic [15:0] out_direction_y;
  logic [14:0] out_adjusted_magnitude;
  logic [16:0] out_scaled_magnitude;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [14:0] cfg_data;

  sample_t       sample_q[$];
  stick_result_t predicted_q[$];
  int unsigned   radius;
  int            error_count;
  bit            quiet;
  bit            in_taken;
  int            send_gap;
  int            recv_gap;
  int            idle_cycles;

  radial_stick_deadzone_core #(.AXIS_MAX(AXIS_MAX)) DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_stick_x            (in_stick_x),
    .in_stick_y            (in_stick_y),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_in_deadzone       (out_in_deadzone),
    .out_direction_x       (out_direction_x),
    .out_direction_y       (out_direction_y),
    .out_adjusted_magnitude(out_adjusted_magnitude),
    .out_scaled_magnitude  (out_scaled_magnitude),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_data              (cfg_data)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #HALF_CLK clk = ~clk;

  // Floor of the square root, one result bit per pass.
  function automatic int unsigned floor_sqrt(int unsigned v);
    int unsigned res;
    int unsigned bitv;
    res  = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // One axis over the magnitude in Q1.15; only the positive side saturates.
  function automatic logic [15:0] unit_axis(int c, int unsigned mag);
    longint unsigned q;
    longint r;
    if (mag == 0) return 16'd0;
    q = (longint'(c < 0 ? -c : c) * 32768) / mag;
    if (c < 0) begin
      r = -longint'(q);
    end else begin
      r = (q > 32767) ? 32767 : longint'(q);
    end
    return r[15:0];
  endfunction

  // Expected response for one stick sample at the current radius.
  function automatic stick_result_t predict_deadzone(sample_t s, int unsigned dz);
    stick_result_t   r;
    int              x;
    int              y;
    int unsigned     mag;
    int unsigned     clipped;
    longint unsigned adj;
    longint unsigned scaled;
    x   = $signed(s.sx);
    y   = $signed(s.sy);
    mag = floor_sqrt(int'(x * x + y * y));
    adj = 0;
    scaled = 0;
    r.in_dz = (mag <= dz);
    if (!r.in_dz) begin
      clipped = (mag > AXIS_MAX) ? AXIS_MAX : mag;
      adj = (clipped > dz) ? clipped - dz : 0;
      if (AXIS_MAX > dz) scaled = (adj * 65536) / (AXIS_MAX - dz);
      else scaled = 65536;
    end
    r.dir_x  = unit_axis(x, mag);
    r.dir_y  = unit_axis(y, mag);
    r.adj    = adj[14:0];
    r.scaled = scaled[16:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
  endtask

  // Input driver: a stalled request holds; otherwise pick a gap or the next sample.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        sample_t s;
        s = sample_q.pop_front();
        in_stick_x <= s.sx;
        in_stick_y <= s.sy;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall driver.
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      recv_gap  <= recv_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap  <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict accepted requests, check accepted results.
  always @(posedge clk) begin
    in_taken = in_valid && !in_stall;
    if (rst_n && in_taken)
      predicted_q.push_back(predict_deadzone({in_stick_x, in_stick_y}, radius));
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        stick_result_t e;
        e = predicted_q.pop_front();
        if (out_in_deadzone !== e.in_dz)
          report_mismatch("in_deadzone", out_in_deadzone, e.in_dz);
        if (out_direction_x !== e.dir_x)
          report_mismatch("direction_x", $signed(out_direction_x), $signed(e.dir_x));
        if (out_direction_y !== e.dir_y)
          report_mismatch("direction_y", $signed(out_direction_y), $signed(e.dir_y));
        if (out_adjusted_magnitude !== e.adj)
          report_mismatch("adjusted_magnitude", out_adjusted_magnitude, e.adj);
        if (out_scaled_magnitude !== e.scaled)
          report_mismatch("scaled_magnitude", out_scaled_magnitude, e.scaled);
      end
    end
  end

  // Watchdog on cycles with outstanding work and no handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) ||
        (sample_q.size() == 0 && !in_valid && predicted_q.size() == 0 && !cfg_valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_sample(int x, int y);
    sample_t s;
    s.sx = x[15:0];
    s.sy = y[15:0];
    sample_q.push_back(s);
  endtask

  // Waits until every request has gone through and every result came back.
  task automatic drain();
    do @(posedge clk);
    while (sample_q.size() > 0 || in_valid || predicted_q.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_radius(int unsigned value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value[14:0];
    do @(posedge clk);
    while (!cfg_ready);
    radius = value[14:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random samples weighted toward the deadzone edge, the rails and the center.
  task automatic push_random(int count);
    int x;
    int y;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          x = $signed(16'($urandom));
          y = $signed(16'($urandom));
        end
        4, 5: begin
          x = int'(radius) + $urandom_range(0, 4) - 2;
          y = $urandom_range(0, 2);
          if ($urandom_range(0, 1)) x = -x;
          if ($urandom_range(0, 1)) begin
            int t;
            t = x; x = y; y = t;
          end
          if (x > 32767) x = 32767;
          if (y > 32767) y = 32767;
        end
        6, 7: begin
          x = $urandom_range(0, 1) ? -32768 : 32767;
          y = $signed(16'($urandom));
          if ($urandom_range(0, 1)) begin
            int t;
            t = x; x = y; y = t;
          end
        end
        default: begin
          x = int'($urandom_range(0, 6)) - 3;
          y = int'($urandom_range(0, 6)) - 3;
        end
      endcase
      push_sample(x, y);
    end
  endtask

  // Stimulus sequence and end of run.
  initial begin
    int unsigned radii[8];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_stick_x  = '0;
    in_stick_y  = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    radius      = 7849;
    error_count = 0;
    quiet       = 1'b0;
    in_taken    = 1'b0;
    send_gap    = 0;
    recv_gap    = 0;
    idle_cycles = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed samples at the reset radius.
    push_sample(0, 0);
    push_sample(32767, 0);
    push_sample(-32768, 0);
    push_sample(0, 32767);
    push_sample(0, -32768);
    push_sample(32767, 32767);
    push_sample(-32768, -32768);
    push_sample(-32768, 32767);
    push_sample(1, 0);
    push_sample(-1, 0);
    push_sample(0, -1);
    push_sample(7849, 0);
    push_sample(7850, 0);
    push_sample(0, -7850);
    push_sample(32766, 1);
    push_sample(-23170, 23170);
    push_sample(23170, -23171);
    push_sample(3, 4);
    drain();

    radii = '{0, 32766, 32767, 1, $urandom_range(1, 32765), $urandom_range(1, 32765),
              32000, 7849};
    foreach (radii[i]) begin
      write_radius(radii[i]);
      quiet = (i == 7);
      push_sample(0, 0);
      push_sample(32767, 0);
      push_sample(-32768, -32768);
      push_random(100);
      drain();
    end

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/rsdz_pkg.sv
design/rsdz_sqrt.sv
design/rsdz_div.sv
design/radial_stick_deadzone_core.sv
tb/radial_stick_deadzone_core_tb.sv
